// ----- design/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and codes for the k-smallest tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package kst_pkg;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;
   localparam int MAX_KEEP   = 16;   // deepest k; must fit CountWidth

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DUMP   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_REFUSE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_REPLY,
      ST_DUMP
   } state_type;
endpackage
`default_nettype wire

// ----- design/kst_req_if.sv -----
// ----------------------------------------------------------------------------
// kst_req_if
// Request channel: opcode and offered value.
// ----------------------------------------------------------------------------
`default_nettype none
interface kst_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  opcode;
   logic signed [31:0] new_value;
   modport source (output valid, output opcode, output new_value, input ready);
   modport sink   (input valid, input opcode, input new_value, output ready);
endinterface
`default_nettype wire

// ----- design/kst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// kst_rsp_if
// Result channel: one result transaction per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface kst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic signed [31:0] entry_value;
   logic [4:0]  held_count;
   logic        is_full;
   logic        last;
   modport source (output valid, output kind, output entry_value,
                   output held_count, output is_full, output last, input ready);
   modport sink   (input valid, input kind, input entry_value,
                   input held_count, input is_full, input last, output ready);
endinterface
`default_nettype wire

// ----- design/k_smallest_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// k_smallest_tracker_unit
// Keeps the k smallest signed values offered, sorted ascending in a memory.
// ----------------------------------------------------------------------------
// req: opcode 0 inserts new_value, opcode 1 dumps. rsp: an insert gives one
//  transaction with the largest held value; a dump gives held_count entries
//  ascending with last on the final one, or one refusal while fewer than k.
// csr: csr_wr_en/csr_wr_data write k (0 acts as 1, above MAX_KEEP clamps);
//  lowering k below the held count drops the largest values and holds req off while the new top is read back.
// Flow: the memory read is registered. A taken insert shifts each larger
//  entry up one place per cycle, writes the new value into the gap, then
//  reads back the new top into the registered result. A rejected insert or
//  a refusal is registered directly; a dump reads its first entry, then
//  gives one entry per ready cycle. One transaction at a time: req is ready
//  when idle with no result waiting and no csr write in the same cycle.
// Reset: count cleared, k set to MAX_KEEP; memory contents not cleared.
// Stall: a result waits in the output register and req stays not ready.
// ----------------------------------------------------------------------------
`default_nettype none
module k_smallest_tracker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   kst_req_if.sink          req,
   kst_rsp_if.source        rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);
   import kst_pkg::*;

   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW = CountWidth;

   logic signed [ValueWidth-1:0] mem [MAX_KEEP];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] pos_ff, pos_in;        // scan/dump position
   logic [CW-1:0] lim_ff, lim_in;        // zero: insert reply due; all ones: top refresh
   logic signed [ValueWidth-1:0] val_ff, val_in;
   logic          rvalid_ff, rvalid_in;
   logic [1:0]    rkind_ff, rkind_in;
   logic signed [ValueWidth-1:0] rval_ff, rval_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic          rfull_ff, rfull_in;
   logic          rlast_ff, rlast_in;
   logic signed [ValueWidth-1:0] top_ff, top_in;  // largest held value

   // memory ports
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic signed [ValueWidth-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [ValueWidth-1:0] wr_data;

   logic [CW-1:0] csr_k;
   logic [CW:0]   pos_p1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

   always_comb begin
      csr_k = csr_wr_data;
      if (csr_k == '0) csr_k = CW'(1);
      if (csr_k > CW'(MAX_KEEP)) csr_k = CW'(MAX_KEEP);
   end

   assign req.ready       = (state_ff == ST_IDLE) && !rvalid_ff && !csr_wr_en;
   assign rsp.valid       = rvalid_ff;
   assign rsp.kind        = rkind_ff;
   assign rsp.entry_value = rval_ff;
   assign rsp.held_count  = rcnt_ff;
   assign rsp.is_full     = rfull_ff;
   assign rsp.last        = rlast_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      keep_in   = keep_ff;
      pos_in    = pos_ff;
      lim_in    = lim_ff;
      val_in    = val_ff;
      top_in    = top_ff;
      rvalid_in = rvalid_ff;
      rkind_in  = rkind_ff;
      rval_in   = rval_ff;
      rcnt_in   = rcnt_ff;
      rfull_in  = rfull_ff;
      rlast_in  = rlast_ff;
      rd_en     = 1'b0;
      rd_addr   = pos_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = val_ff;
      pos_p1    = {1'b0, pos_ff} + (CW+1)'(1);

      if (rsp.valid && rsp.ready) rvalid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wr_en) begin
               keep_in = csr_k;
               if (count_ff > csr_k) begin
                  // top becomes entry csr_k-1; fetched in ST_SHIFT
                  count_in = csr_k;
                  pos_in   = csr_k - CW'(1);
                  state_in = ST_SHIFT;
                  lim_in   = '1;   // marks a top refresh only
               end
            end else if (req.valid && req.ready) begin
               if (req.opcode == OP_INSERT) begin
                  val_in = req.new_value;
                  if (count_ff < keep_ff) begin
                     lim_in   = count_ff;
                     count_in = count_ff + CW'(1);
                     pos_in   = count_ff;
                     state_in = ST_SCAN;
                  end else if (req.new_value < top_ff) begin
                     lim_in   = count_ff - CW'(1);
                     pos_in   = count_ff - CW'(1);
                     state_in = ST_SCAN;
                  end else begin
                     rvalid_in = 1'b1;
                     rkind_in  = KIND_INSERT;
                     rval_in   = top_ff;
                     rcnt_in   = count_ff;
                     rfull_in  = (count_ff == keep_ff);
                     rlast_in  = 1'b1;
                  end
                  if (state_in == ST_SCAN && pos_in != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(pos_in - CW'(1));
                  end
               end else if (count_ff < keep_ff) begin
                  rvalid_in = 1'b1;
                  rkind_in  = KIND_REFUSE;
                  rval_in   = '0;
                  rcnt_in   = count_ff;
                  rfull_in  = 1'b0;
                  rlast_in  = 1'b1;
               end else begin
                  pos_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_DUMP;
               end
            end
         end
         ST_SCAN: begin
            // rd_data holds entry pos-1 when pos != 0
            if (pos_ff != '0 && rd_data > val_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_data;
               pos_in  = pos_ff - CW'(1);
               if (pos_ff != CW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(pos_ff - CW'(2));
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = val_ff;
               lim_in   = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // placement write is done; fetch the new top entry
            rd_en    = 1'b1;
            rd_addr  = AW'(count_ff - CW'(1));
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            top_in   = rd_data;
            state_in = ST_IDLE;
            if (lim_ff == '0) begin
               rvalid_in = 1'b1;
               rkind_in  = KIND_INSERT;
               rval_in   = rd_data;
               rcnt_in   = count_ff;
               rfull_in  = (count_ff == keep_ff);
               rlast_in  = 1'b1;
            end
         end
         ST_DUMP: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
               rkind_in  = KIND_ENTRY;
               rval_in   = rd_data;
               rcnt_in   = count_ff;
               rfull_in  = 1'b1;
               rlast_in  = (pos_p1 == {1'b0, count_ff});
               pos_in    = pos_p1[CW-1:0];
               if (pos_p1 == {1'b0, count_ff}) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_p1[AW-1:0];
               end
            end else begin
               rd_en   = 1'b1;   // hold read data
               rd_addr = pos_ff[AW-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         keep_ff   <= CW'(MAX_KEEP);
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         keep_ff   <= keep_in;
         rvalid_ff <= rvalid_in;
      end
      pos_ff   <= pos_in;
      lim_ff   <= lim_in;
      val_ff   <= val_in;
      top_ff   <= top_in;
      rkind_ff <= rkind_in;
      rval_ff  <= rval_in;
      rcnt_ff  <= rcnt_in;
      rfull_ff <= rfull_in;
      rlast_ff <= rlast_in;
   end
endmodule
`default_nettype wire
